[hdl/gclf_pkg.sv]
package gclf_pkg;

    // Decimal digits sent for the line number (lowest ones kept).
    localparam int NUMBER_DIGITS = 10;

    // Line numbers are non-negative 32-bit values: 31 magnitude bits.
    localparam int NUM_BITS   = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int DIG_W      = $clog2(BCD_DIGITS);
    localparam int CNT_W      = $clog2(NUM_BITS);
    localparam int EMIT_MAX   = (NUMBER_DIGITS < BCD_DIGITS) ? NUMBER_DIGITS : BCD_DIGITS;

    // Command queue between front and back; depth must be a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // One classified input item.
    typedef struct packed {
        logic                hdr;        // send N<number><space> first
        logic                first;      // line start: clear checksum
        logic                nl;         // release a held newline
        logic                body;       // send body_byte
        logic [7:0]          body_byte;
        logic                trl;        // close the line
        logic                numbered;   // trailer carries *<checksum>
        logic [NUM_BITS-1:0] lnum;
    } gclf_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gclf_q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_HDR_N,
        ST_HDR_DIG,
        ST_HDR_SP,
        ST_NL,
        ST_BODY,
        ST_STAR,
        ST_CHK_DIG,
        ST_END_NL
    } gclf_state_t;

    // One double-dabble step: adjust each digit, shift in the next binary bit.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (adj[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // Index of the first digit to send: highest nonzero digit, capped at the
    // digit limit (a truncated number keeps its inner zeros).
    function automatic logic [DIG_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
        logic [DIG_W-1:0] top;
        top = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                top = (i < EMIT_MAX) ? DIG_W'(i) : DIG_W'(EMIT_MAX - 1);
            end
        end
        return top;
    endfunction

    // Checksum to three BCD digits {hundreds, tens, ones}.
    function automatic logic [11:0] chk_digits(input logic [7:0] v);
        logic [1:0]  hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        if (v >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(v - 8'd200);
        end
        else if (v >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(v - 8'd100);
        end
        else begin
            hund = 2'd0;
            rem  = v[6:0];
        end
        // rem / 10 as (rem * 205) >> 11, exact for rem < 1029
        prod     = 15'(rem) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones     = 4'(rem - tens_x10);
        return {2'b00, hund, tens, ones};
    endfunction

    function automatic logic [1:0] chk_top(input logic [7:0] v);
        logic [1:0] top;
        if (v >= 8'd100) begin
            top = 2'd2;
        end
        else if (v >= 8'd10) begin
            top = 2'd1;
        end
        else begin
            top = 2'd0;
        end
        return top;
    endfunction

endpackage

[hdl/gclf_front.sv]
module gclf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    input  logic signed [31:0]     line_number,
    input  gclf_pkg::gclf_q_stat_t q_stat,
    output logic                   push,
    output gclf_pkg::gclf_cmd_t    cmd
);

    logic comment_reg, comment_next;
    logic held_reg, held_next;
    logic numbered_reg, numbered_next;

    logic comment_eff;
    logic held_eff;
    logic numbered_eff;

    assign in_stall = q_stat.full;
    assign push     = in_valid & ~q_stat.full;

    always_comb
    begin
        // a first byte abandons whatever line was open
        comment_eff  = first_byte ? 1'b0 : comment_reg;
        held_eff     = first_byte ? 1'b0 : held_reg;
        numbered_eff = first_byte ? ~line_number[31] : numbered_reg;

        cmd.hdr       = first_byte & ~line_number[31];
        cmd.first     = first_byte;
        cmd.nl        = 1'b0;
        cmd.body      = 1'b0;
        cmd.body_byte = in_byte;
        cmd.trl       = last_byte;
        cmd.numbered  = numbered_eff;
        cmd.lnum      = line_number[gclf_pkg::NUM_BITS-1:0];

        comment_next = comment_eff;
        held_next    = held_eff;

        if (!comment_eff) begin
            if (in_byte == gclf_pkg::CH_SEMI) begin
                comment_next = 1'b1;
            end
            else if (in_byte == gclf_pkg::CH_NL) begin
                cmd.nl    = held_eff;
                held_next = 1'b1;
            end
            else begin
                cmd.nl    = held_eff;
                held_next = 1'b0;
                cmd.body  = 1'b1;
            end
        end

        numbered_next = numbered_eff;
        if (last_byte) begin
            // a held newline at line end is dropped
            comment_next  = 1'b0;
            held_next     = 1'b0;
            numbered_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            comment_reg  <= 1'b0;
            held_reg     <= 1'b0;
            numbered_reg <= 1'b0;
        end
        else if (push) begin
            comment_reg  <= comment_next;
            held_reg     <= held_next;
            numbered_reg <= numbered_next;
        end
    end

endmodule

[hdl/gclf_queue.sv]
module gclf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  gclf_pkg::gclf_cmd_t    push_cmd,
    input  logic                   pop,
    output gclf_pkg::gclf_cmd_t    pop_cmd,
    output gclf_pkg::gclf_q_stat_t q_stat
);

    gclf_pkg::gclf_cmd_t mem_reg [gclf_pkg::Q_DEPTH];

    logic [gclf_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gclf_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gclf_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == gclf_pkg::Q_CNT_W'(gclf_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + gclf_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + gclf_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + gclf_pkg::Q_CNT_W'(1);
            2'b01:   count_next = count_reg - gclf_pkg::Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/gclf_back.sv]
module gclf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gclf_pkg::gclf_q_stat_t q_stat,
    input  gclf_pkg::gclf_cmd_t    q_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    gclf_pkg::gclf_state_t state_reg, state_next;
    gclf_pkg::gclf_cmd_t   cmd_reg, cmd_next;

    logic [gclf_pkg::NUM_BITS-1:0] bin_reg, bin_next;
    logic [gclf_pkg::BCD_W-1:0]    bcd_reg, bcd_next;
    logic [gclf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [gclf_pkg::DIG_W-1:0]    dig_reg, dig_next;
    logic [11:0]                   chk_reg, chk_next;
    logic [1:0]                    cidx_reg, cidx_next;
    logic [7:0]                    xor_reg, xor_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       can_emit;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       fold;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign can_emit  = ~out_valid_reg | ~out_stall;

    // What follows the header (or comes first without one).
    function automatic gclf_pkg::gclf_state_t route(input gclf_pkg::gclf_cmd_t c);
        gclf_pkg::gclf_state_t s;
        if (c.nl) begin
            s = gclf_pkg::ST_NL;
        end
        else if (c.body) begin
            s = gclf_pkg::ST_BODY;
        end
        else if (c.trl) begin
            s = c.numbered ? gclf_pkg::ST_STAR : gclf_pkg::ST_END_NL;
        end
        else begin
            s = gclf_pkg::ST_IDLE;
        end
        return s;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        chk_next   = chk_reg;
        cidx_next  = cidx_reg;
        xor_next   = xor_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_byte  = gclf_pkg::CH_NL;
        emit_last  = 1'b0;
        fold       = 1'b0;

        case (state_reg)
            gclf_pkg::ST_IDLE:
            begin
                if (!q_stat.empty) begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.first) begin
                        xor_next = 8'h00;
                    end
                    bin_next   = q_cmd.lnum;
                    bcd_next   = '0;
                    cnt_next   = gclf_pkg::CNT_W'(gclf_pkg::NUM_BITS - 1);
                    state_next = q_cmd.hdr ? gclf_pkg::ST_CONV : route(q_cmd);
                end
            end
            gclf_pkg::ST_CONV:
            begin
                bcd_next = gclf_pkg::dabble_step(bcd_reg, bin_reg[gclf_pkg::NUM_BITS-1]);
                bin_next = {bin_reg[gclf_pkg::NUM_BITS-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    state_next = gclf_pkg::ST_HDR_N;
                end
                else begin
                    cnt_next = cnt_reg - gclf_pkg::CNT_W'(1);
                end
            end
            gclf_pkg::ST_HDR_N:
            begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_byte  = gclf_pkg::CH_N;
                    fold       = 1'b1;
                    dig_next   = gclf_pkg::top_digit(bcd_reg);
                    state_next = gclf_pkg::ST_HDR_DIG;
                end
            end
            gclf_pkg::ST_HDR_DIG:
            begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = {gclf_pkg::CH_DIGIT_HI, bcd_reg[dig_reg*4 +: 4]};
                    fold      = 1'b1;
                    if (dig_reg == '0) begin
                        state_next = gclf_pkg::ST_HDR_SP;
                    end
                    else begin
                        dig_next = dig_reg - gclf_pkg::DIG_W'(1);
                    end
                end
            end
            gclf_pkg::ST_HDR_SP:
            begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_byte  = gclf_pkg::CH_SPACE;
                    fold       = 1'b1;
                    state_next = route(cmd_reg);
                end
            end
            gclf_pkg::ST_NL:
            begin
                if (can_emit) begin
                    emit        = 1'b1;
                    emit_byte   = gclf_pkg::CH_NL;
                    fold        = 1'b1;
                    cmd_next.nl = 1'b0;
                    state_next  = route(cmd_next);
                end
            end
            gclf_pkg::ST_BODY:
            begin
                if (can_emit) begin
                    emit          = 1'b1;
                    emit_byte     = cmd_reg.body_byte;
                    fold          = 1'b1;
                    cmd_next.body = 1'b0;
                    state_next    = route(cmd_next);
                end
            end
            gclf_pkg::ST_STAR:
            begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_byte  = gclf_pkg::CH_STAR;
                    chk_next   = gclf_pkg::chk_digits(xor_reg);
                    cidx_next  = gclf_pkg::chk_top(xor_reg);
                    state_next = gclf_pkg::ST_CHK_DIG;
                end
            end
            gclf_pkg::ST_CHK_DIG:
            begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = {gclf_pkg::CH_DIGIT_HI, chk_reg[cidx_reg*4 +: 4]};
                    if (cidx_reg == 2'd0) begin
                        state_next = gclf_pkg::ST_END_NL;
                    end
                    else begin
                        cidx_next = cidx_reg - 2'd1;
                    end
                end
            end
            gclf_pkg::ST_END_NL:
            begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_byte  = gclf_pkg::CH_NL;
                    emit_last  = 1'b1;
                    xor_next   = 8'h00;
                    state_next = gclf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gclf_pkg::ST_IDLE;
            end
        endcase

        if (fold) begin
            xor_next = xor_reg ^ emit_byte;
        end

        out_valid_next = out_valid_reg & out_stall;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= gclf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            xor_reg       <= 8'h00;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            xor_reg       <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        dig_reg      <= dig_next;
        chk_reg      <= chk_next;
        cidx_reg     <= cidx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

[hdl/gcode_line_framer.sv]
// Frames one line of a printer command stream.
// Input channel (in_valid/in_stall): one source character per item, with
// first_byte/last_byte marking line boundaries; line_number is sampled on the
// first byte, a negative value sends the line without number and checksum.
// Output channel (out_valid/out_stall): one framed character per item;
// out_last marks the closing newline. Comments (';' onward) are dropped and
// a trailing newline is swallowed; numbered lines get "N<num> " in front and
// a "*<xor>" checksum in decimal plus newline at the end.
// The back end takes an item from the queue in its idle state and then
// emits one character per cycle unless the output is stalled; a comment
// character produces no output. A numbered first byte first runs a
// bit-serial binary-to-decimal conversion before its header goes out.
// A body byte passes the command queue and the back end's idle and body states.
// A two-entry command queue lets the front keep taking items while the back
// works; in_stall rises only when that queue is full.
// Out_stall holds the output register; the back end waits, then the queue
// fills and the input stalls. Reset empties the queue and clears all line
// state; no output is pending after reset.
module gcode_line_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    input  logic signed [31:0] line_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    gclf_pkg::gclf_q_stat_t q_stat;
    gclf_pkg::gclf_cmd_t    push_cmd;
    gclf_pkg::gclf_cmd_t    pop_cmd;
    logic                   push;
    logic                   pop;

    // front: tracks comment/newline state and classifies each item
    gclf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .line_number (line_number),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (push_cmd)
    );

    gclf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // back: header, body, trailer sequencing and running checksum
    gclf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

`ifndef SYNTHESIS
    // only the closing newline carries out_last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_byte == gclf_pkg::CH_NL)
        else $error("out_last on a character other than newline");

    // front never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // back never reads an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command queue underflow");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // One framed character as it leaves the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } framed_char_t;

    // Directed stimulus row. An empty want string means the predictor supplies
    // the expected characters; otherwise want is the whole framed line.
    typedef struct {
        logic [7:0] ch;
        bit         first;
        bit         last;
        int         lnum;
        string      want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte = 8'h00;
    logic               first_byte = 1'b0;
    logic               last_byte = 1'b0;
    logic signed [31:0] line_number = 32'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               out_last;

    // Chance per cycle, in percent, of a sender gap and of a receiver stall.
    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;

    // Characters still owed by the block, oldest first.
    framed_char_t framed_chars[$];
    framed_char_t head_c;

    // Line state mirrored from the block.
    bit         trk_in_comment = 1'b0;
    bit         trk_held_nl = 1'b0;
    logic [7:0] trk_xor = 8'h00;
    bit         trk_numbered = 1'b0;

    // Mostly G-code text, so comments and newlines fall inside real-looking lines.
    string gcode_chars = "GMXYZEFST0123456789.- ";

    // Directed part: extremes of line number and byte, comment handling, held
    // newlines, abandoned lines and bytes that arrive outside a line.
    dir_row_t dir_tab [0:24] = '{
        // unnumbered single-byte line, low and high byte values
        '{"G",     1, 1, -1,           "G\n"},
        '{8'hFF,   1, 1, -1,           "\377\n"},
        '{8'h00,   1, 1, -1,           ""},
        // numbered line 0 that is all comment: header and trailer only
        '{gclf_pkg::CH_SEMI, 1, 1, 0,  "N0 *94\n"},
        // largest line number, a high byte, two newlines then a body byte
        '{"G",     1, 0, 2147483647,   ""},
        '{"1",     0, 0, 2147483647,   ""},
        '{8'h80,   0, 0, 2147483647,   ""},
        '{gclf_pkg::CH_NL, 0, 0, 2147483647, ""},
        '{gclf_pkg::CH_NL, 0, 0, 2147483647, ""},
        '{"X",     0, 1, 2147483647,   ""},
        // most negative line number; trailing newline gets swallowed
        '{"M",     1, 0, 32'h8000_0000, ""},
        '{gclf_pkg::CH_NL, 0, 0, 32'h8000_0000, ""},
        '{gclf_pkg::CH_NL, 0, 1, 32'h8000_0000, ""},
        // number with inner zeros, comment to end of line
        '{"G",     1, 0, 1000000000,   ""},
        '{gclf_pkg::CH_SEMI, 0, 0, 1000000000, ""},
        '{"x",     0, 0, 1000000000,   ""},
        '{gclf_pkg::CH_NL, 0, 1, 1000000000, ""},
        // new first byte while a line (with held newline) is still open
        '{"A",     1, 0, 3,            ""},
        '{gclf_pkg::CH_NL, 0, 0, 3,    ""},
        '{"B",     1, 0, 10,           ""},
        '{"C",     0, 1, 10,           ""},
        // bytes with no first byte after a closed line
        '{"Z",     0, 0, -1,           ""},
        '{8'h7F,   0, 0, 55,           ""},
        '{"Q",     0, 1, -1,           ""},
        // newline as first and last byte of a numbered line
        '{gclf_pkg::CH_NL, 1, 1, 99,   ""}
    };

    gcode_line_framer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .line_number (line_number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Line framing predictor
    // ---------------------------------------------------------------------

    // Queue one framed char; fold it into the checksum where it belongs.
    function automatic void put_framed_char(logic [7:0] ch, bit last, bit fold, bit record);
        if (record)
        begin
            framed_chars.push_back('{ch, last});
        end
        if (fold)
        begin
            trk_xor = trk_xor ^ ch;
        end
    endfunction

    // Decimal, no leading zeros, lowest max_digits digits only.
    function automatic void put_decimal(longint unsigned v, int max_digits, bit fold,
                                        bit record);
        logic [3:0] digs [20];
        int         cnt;
        cnt = 0;
        do
        begin
            digs[cnt] = 4'(v % 10);
            v = v / 10;
            cnt++;
        end
        while (v != 0 && cnt < max_digits && cnt < 20);
        for (int i = cnt - 1; i >= 0; i--)
        begin
            put_framed_char({4'h3, digs[i]}, 1'b0, fold, record);
        end
    endfunction

    function automatic void clear_line_state();
        trk_in_comment = 1'b0;
        trk_held_nl = 1'b0;
        trk_xor = 8'h00;
        trk_numbered = 1'b0;
    endfunction

    // Advance the line state by one source byte and queue what it produces.
    function automatic void frame_source_byte(logic [7:0] ch, bit first, bit last,
                                              logic signed [31:0] lnum, bit record);
        if (first)
        begin
            clear_line_state();
            if (!lnum[31])
            begin
                trk_numbered = 1'b1;
                put_framed_char(gclf_pkg::CH_N, 1'b0, 1'b1, record);
                put_decimal(longint'(lnum[30:0]), gclf_pkg::NUMBER_DIGITS, 1'b1, record);
                put_framed_char(gclf_pkg::CH_SPACE, 1'b0, 1'b1, record);
            end
        end
        if (!trk_in_comment)
        begin
            if (ch == gclf_pkg::CH_SEMI)
            begin
                trk_in_comment = 1'b1;
            end
            else if (ch == gclf_pkg::CH_NL)
            begin
                // previous held newline goes out, this one is held in its place
                if (trk_held_nl)
                begin
                    put_framed_char(gclf_pkg::CH_NL, 1'b0, 1'b1, record);
                end
                trk_held_nl = 1'b1;
            end
            else
            begin
                if (trk_held_nl)
                begin
                    put_framed_char(gclf_pkg::CH_NL, 1'b0, 1'b1, record);
                end
                trk_held_nl = 1'b0;
                put_framed_char(ch, 1'b0, 1'b1, record);
            end
        end
        if (last)
        begin
            // trailer is not part of the checksum; a held newline is dropped
            if (trk_numbered)
            begin
                put_framed_char(gclf_pkg::CH_STAR, 1'b0, 1'b0, record);
                put_decimal(longint'(trk_xor), 3, 1'b0, record);
            end
            put_framed_char(gclf_pkg::CH_NL, 1'b1, 1'b0, record);
            clear_line_state();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------

    // Called at a rising edge; returns at the edge where the item was taken.
    // Stall is looked at on the falling edge, where it is settled.
    task automatic drive_item(logic [7:0] ch, bit first, bit last,
                              logic signed [31:0] lnum, bit record);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= ch;
        first_byte  <= first;
        last_byte   <= last;
        line_number <= lnum;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        frame_source_byte(ch, first, last, lnum, record);
    endtask

    // Lower valid and wait for every owed char to come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (framed_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return gcode_chars[$urandom_range(gcode_chars.len() - 1)];
        end
        else if (r < 65)
        begin
            return gclf_pkg::CH_SEMI;
        end
        else if (r < 80)
        begin
            return gclf_pkg::CH_NL;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic signed [31:0] pick_line_number();
        logic signed [31:0] v;
        case ($urandom_range(7))
            0: v = -1;
            1: v = {1'b1, 31'($urandom)};
            2: v = $urandom_range(9);
            3: v = $urandom_range(9999);
            4: v = {1'b0, 31'($urandom)};
            5: v = 32'h7FFF_FFFF;
            6: v = 1000000000 + $urandom_range(999);
            default: v = $urandom_range(200);
        endcase
        return v;
    endfunction

    // Mostly well-formed lines with random content; a few abandoned lines,
    // stray bytes outside a line and items with random flags.
    task automatic send_random_lines(int n_items);
        int                 sent;
        int                 kind;
        int                 len;
        logic signed [31:0] lnum;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(19);
            len  = $urandom_range(1, 8);
            lnum = pick_line_number();
            if (kind == 0)
            begin
                drive_item(pick_char(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                           $urandom, 1'b1);
                len = 1;
            end
            else if (kind == 1)
            begin
                // no last byte: the next first byte abandons it
                for (int i = 0; i < len; i++)
                begin
                    drive_item(pick_char(), i == 0, 1'b0, lnum, 1'b1);
                end
            end
            else if (kind == 2)
            begin
                // no first byte: unnumbered unless an abandoned line is still open; closed by its last byte
                for (int i = 0; i < len; i++)
                begin
                    drive_item(pick_char(), 1'b0, i == len - 1, lnum, 1'b1);
                end
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    drive_item(pick_char(), i == 0, i == len - 1, lnum, 1'b1);
                end
            end
            sent += len;
        end
    endtask

    // ---------------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (framed_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, got %02h last %b",
                         $time, out_byte, out_last);
                errors++;
            end
            else
            begin
                head_c = framed_chars.pop_front();
                if (out_byte !== head_c.ch)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, head_c.ch, out_byte);
                    errors++;
                end
                if (out_last !== head_c.last)
                begin
                    $display("%0t: out_last expected %b, got %b",
                             $time, head_c.last, out_last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no idling: directed rows, then random lines
        idle_pct = 0;
        stall_pct = 0;
        for (int r = 0; r < 25; r++)
        begin
            drive_item(dir_tab[r].ch, dir_tab[r].first, dir_tab[r].last,
                       dir_tab[r].lnum, dir_tab[r].want.len() == 0);
            for (int k = 0; k < dir_tab[r].want.len(); k++)
            begin
                framed_chars.push_back('{dir_tab[r].want[k],
                                         k == dir_tab[r].want.len() - 1});
            end
        end
        send_random_lines(110);
        // sender holds off until the block has caught up
        drain_outputs();

        // sender mostly idle
        idle_pct = 87;
        stall_pct = 0;
        send_random_lines(115);
        drain_outputs();

        // receiver mostly stalled; the queue fills and input stalls
        idle_pct = 0;
        stall_pct = 87;
        send_random_lines(115);
        drain_outputs();

        // light gaps on both sides
        idle_pct = 18;
        stall_pct = 18;
        send_random_lines(115);
        drain_outputs();

        // catch any stray char after the last expected one
        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d chars still expected", $time, framed_chars.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
